### hw/rtl/ted_pkg.sv
`default_nettype none

package ted_pkg;

	localparam int LENGTH_BITS_DEF = 24;

	localparam logic [2:0] ENC_ANSI    = 3'd0;
	localparam logic [2:0] ENC_UTF8    = 3'd1;
	localparam logic [2:0] ENC_UTF16LE = 3'd2;
	localparam logic [2:0] ENC_UTF16BE = 3'd3;
	localparam logic [2:0] ENC_UTF32LE = 3'd4;
	localparam logic [2:0] ENC_UTF32BE = 3'd5;
	localparam logic [2:0] ENC_BINARY  = 3'd6;

	localparam logic [31:0] BOM_UTF32LE = 32'h0000_FEFF;
	localparam logic [31:0] BOM_UTF32BE = 32'hFFFE_0000;
	localparam logic [15:0] BOM_UTF16LE = 16'hFEFF;
	localparam logic [15:0] BOM_UTF16BE = 16'hFFFE;
	localparam logic [15:0] BOM_UTF8_HEAD = 16'hBBEF;
	localparam logic [7:0]  BOM_UTF8_TAIL = 8'hBF;

	localparam logic [7:0] LEAD2_MAX_BAD = 8'hC1;
	localparam logic [7:0] LEAD4_MIN_BAD = 8'hF5;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} step_t;

	typedef struct packed {
		logic [2:0] encoding;
		logic       has_bom;
		logic       inconclusive;
		logic [1:0] pending;
	} verdict_t;

endpackage

`default_nettype wire

### hw/rtl/ted_track.sv
`default_nettype none

module ted_track #(
	parameter int LENGTH_BITS = ted_pkg::LENGTH_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire ted_pkg::step_t     step,
	input  wire  [LENGTH_BITS-1:0]  buffer_length,
	output ted_pkg::verdict_t       verdict
);

	localparam int DW = LENGTH_BITS - 2;
	localparam int PW = LENGTH_BITS + 6;

	logic [LENGTH_BITS-1:0] pos_q, pos_d;
	logic [31:0]            head_q, head_d;
	logic                   az_q, az_d;
	logic [DW-1:0]          zdc_q, zdc_d;
	logic [LENGTH_BITS-1:0] zbc_q, zbc_d;
	logic [1:0]             need_q, need_d;
	logic                   non_ascii_q, non_ascii_d;
	logic                   stopped_q, stopped_d;
	logic [2:0]             sverd_q, sverd_d;
	logic [1:0]             sskip_q, sskip_d;

	logic [7:0]             z;
	logic [PW-1:0]          prod;
	logic [LENGTH_BITS-1:0] max_null;

	assign z = step.data;

	always_comb begin
		pos_d       = pos_q;
		head_d      = head_q;
		az_d        = az_q;
		zdc_d       = zdc_q;
		zbc_d       = zbc_q;
		need_d      = need_q;
		non_ascii_d = non_ascii_q;
		stopped_d   = stopped_q;
		sverd_d     = sverd_q;
		sskip_d     = sskip_q;
		if (!stopped_q && z == 8'd0 && pos_q < buffer_length && zbc_q != '1) begin
			zbc_d = zbc_q + 1'b1;
		end
		prod = ({6'd0, zbc_d} << 5) + ({6'd0, zbc_d} << 4) + ({6'd0, zbc_d} << 1);
		if (pos_q < buffer_length) begin
			pos_d = pos_q + 1'b1;
			if (pos_q < LENGTH_BITS'(4)) begin
				head_d = head_q | ({24'd0, z} << {pos_q[1:0], 3'b000});
			end
			az_d = az_q & (z == 8'd0);
			if (pos_q[1:0] == 2'd3) begin
				if (az_d && zdc_q != '1) begin
					zdc_d = zdc_q + 1'b1;
				end
				az_d = 1'b1;
			end
			if (!stopped_q) begin
				if (!z[7]) begin
					if (z == 8'd0) begin
						if ({6'd0, buffer_length} < prod) begin
							stopped_d = 1'b1;
							sverd_d   = pos_q[0] ? ted_pkg::ENC_UTF16LE : ted_pkg::ENC_UTF16BE;
							sskip_d   = 2'd0;
						end else begin
							need_d = 2'd0;
						end
					end else if (need_q != 2'd0) begin
						stopped_d = 1'b1;
						sverd_d   = ted_pkg::ENC_ANSI;
						sskip_d   = need_q;
					end
				end else begin
					non_ascii_d = 1'b1;
					if (!z[6]) begin
						if (need_q == 2'd0) begin
							stopped_d = 1'b1;
							sverd_d   = ted_pkg::ENC_ANSI;
							sskip_d   = 2'd0;
						end else begin
							need_d = need_q - 1'b1;
						end
					end else if (need_q != 2'd0) begin
						stopped_d = 1'b1;
						sverd_d   = ted_pkg::ENC_ANSI;
						sskip_d   = need_q;
					end else if (!z[5]) begin
						if (z <= ted_pkg::LEAD2_MAX_BAD) begin
							stopped_d = 1'b1;
							sverd_d   = ted_pkg::ENC_ANSI;
							sskip_d   = 2'd0;
						end else begin
							need_d = 2'd1;
						end
					end else if (!z[4]) begin
						need_d = 2'd2;
					end else if (!z[3] && z < ted_pkg::LEAD4_MIN_BAD) begin
						need_d = 2'd3;
					end else begin
						stopped_d = 1'b1;
						sverd_d   = ted_pkg::ENC_ANSI;
						sskip_d   = 2'd0;
					end
				end
			end
		end
	end

	always_comb begin
		max_null = buffer_length >> 10;
		if (max_null == '0) begin
			max_null = LENGTH_BITS'(1);
		end
		verdict = '{encoding: ted_pkg::ENC_ANSI, has_bom: 1'b0, inconclusive: 1'b0,
			pending: 2'd0};
		if (buffer_length < LENGTH_BITS'(2)) begin
			verdict.inconclusive = 1'b1;
		end else if (buffer_length >= LENGTH_BITS'(4) && head_d == ted_pkg::BOM_UTF32LE) begin
			verdict.encoding = ted_pkg::ENC_UTF32LE;
			verdict.has_bom  = 1'b1;
		end else if (buffer_length >= LENGTH_BITS'(4) && head_d == ted_pkg::BOM_UTF32BE) begin
			verdict.encoding = ted_pkg::ENC_UTF32BE;
			verdict.has_bom  = 1'b1;
		end else if ({2'd0, zdc_d} > max_null) begin
			verdict.encoding = ted_pkg::ENC_BINARY;
		end else if (head_d[15:0] == ted_pkg::BOM_UTF16LE) begin
			verdict.encoding = ted_pkg::ENC_UTF16LE;
			verdict.has_bom  = 1'b1;
		end else if (head_d[15:0] == ted_pkg::BOM_UTF16BE) begin
			verdict.encoding = ted_pkg::ENC_UTF16BE;
			verdict.has_bom  = 1'b1;
		end else if (buffer_length < LENGTH_BITS'(3)) begin
			verdict.inconclusive = 1'b1;
		end else if (head_d[15:0] == ted_pkg::BOM_UTF8_HEAD &&
				head_d[23:16] == ted_pkg::BOM_UTF8_TAIL) begin
			verdict.encoding = ted_pkg::ENC_UTF8;
			verdict.has_bom  = 1'b1;
		end else if (stopped_d) begin
			verdict.encoding = sverd_d;
			verdict.pending  = sskip_d;
		end else if (non_ascii_d && need_d == 2'd0) begin
			verdict.encoding = ted_pkg::ENC_UTF8;
		end else begin
			verdict.inconclusive = 1'b1;
			verdict.pending      = need_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			head_q      <= '0;
			az_q        <= 1'b1;
			zdc_q       <= '0;
			zbc_q       <= '0;
			need_q      <= 2'd0;
			non_ascii_q <= 1'b0;
			stopped_q   <= 1'b0;
			sverd_q     <= ted_pkg::ENC_ANSI;
			sskip_q     <= 2'd0;
		end else if (step.valid) begin
			if (step.last) begin
				pos_q       <= '0;
				head_q      <= '0;
				az_q        <= 1'b1;
				zdc_q       <= '0;
				zbc_q       <= '0;
				need_q      <= 2'd0;
				non_ascii_q <= 1'b0;
				stopped_q   <= 1'b0;
				sverd_q     <= ted_pkg::ENC_ANSI;
				sskip_q     <= 2'd0;
			end else begin
				pos_q       <= pos_d;
				head_q      <= head_d;
				az_q        <= az_d;
				zdc_q       <= zdc_d;
				zbc_q       <= zbc_d;
				need_q      <= need_d;
				non_ascii_q <= non_ascii_d;
				stopped_q   <= stopped_d;
				sverd_q     <= sverd_d;
				sskip_q     <= sskip_d;
			end
		end
	end

	ap_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= buffer_length || pos_q == '0)
		else $error("byte position ran past buffer length");

	ap_stopped_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && !(step.valid && step.last) |=> stopped_q)
		else $error("scan failure was not latched");

	ap_need_lead: assert property (@(posedge clk) disable iff (!arst_n)
		need_q != 2'd0 |-> non_ascii_q)
		else $error("continuations expected without a lead byte");

endmodule

`default_nettype wire

### hw/rtl/text_encoding_detector.sv
`default_nettype none

// Text encoding detector.
// Feed the buffer one byte per beat on the input channel (in_valid / in_stall,
// data_byte, last_byte). Mark the final byte with last_byte; that beat gives
// one verdict beat on the output channel (out_valid / out_stall, encoding,
// has_bom, inconclusive, pending_continuations). Other beats give nothing.
// Write buffer_length through cfg_valid / cfg_ready (always ready) before the
// buffer starts, while the block is idle; it holds across buffers.
// Bytes beyond buffer_length are dropped, though their last mark still counts.
// Throughput: one byte per cycle while in_stall is low. A last byte is taken
// into the input register; its verdict then loads the result register.
// While the receiver stalls, the verdict holds and further non-final bytes
// still flow; in_stall rises only when a second final byte meets a stalled,
// occupied result register.
// Reset clears the length register to zero and all per-buffer state; after
// each verdict the per-buffer state returns to its reset value.

module text_encoding_detector #(
	parameter int LENGTH_BITS = ted_pkg::LENGTH_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [7:0]             data_byte,
	input  wire                    last_byte,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [2:0]             encoding,
	output logic                   has_bom,
	output logic                   inconclusive,
	output logic [1:0]             pending_continuations,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [LENGTH_BITS-1:0] buffer_length
);

	logic [LENGTH_BITS-1:0] length_q;
	logic                   valid_s1;
	logic                   last_s1;
	logic [7:0]             data_s1;
	logic                   advance;
	logic                   load;
	logic                   out_valid_q;
	ted_pkg::step_t         step;
	ted_pkg::verdict_t      verdict;
	ted_pkg::verdict_t      result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cfg_valid) begin
			length_q <= buffer_length;
		end
	end

	assign advance  = !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = valid_s1 && advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
			last_s1  <= in_valid && last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	assign step = '{valid: valid_s1 && advance, last: last_s1, data: data_s1};

	ted_track #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.buffer_length(length_q),
		.verdict      (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= verdict;
		end
	end

	assign out_valid             = out_valid_q;
	assign encoding              = result_q.encoding;
	assign has_bom               = result_q.has_bom;
	assign inconclusive          = result_q.inconclusive;
	assign pending_continuations = result_q.pending;

	ap_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked verdict");

	ap_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("loaded verdict not presented");

	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !load)
		else $error("stalled verdict overwritten");

	ap_bom_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.has_bom |-> !result_q.inconclusive && result_q.pending == 2'd0)
		else $error("byte order mark verdict carries scan status");

endmodule

`default_nettype wire
